[hw/rtl/alc_pkg.sv]
// shared constants, codes and types of the average-link clustering engine
package alc_pkg;

  localparam int unsigned MAX_POINTS = 64;
  localparam int unsigned MAX_DIMS   = 16;
  localparam int unsigned ID_SPACE   = 2 * MAX_POINTS;

  localparam int unsigned COORD_W = 16;
  localparam int unsigned DIMS_W  = 5;
  localparam int unsigned DIDX_W  = $clog2(MAX_DIMS);
  localparam int unsigned PIDX_W  = $clog2(MAX_POINTS);
  localparam int unsigned ID_W    = $clog2(ID_SPACE);
  localparam int unsigned PT_AW   = PIDX_W + DIDX_W;
  localparam int unsigned DM_AW   = 2 * ID_W;
  localparam int unsigned DIST_W  = 22;
  localparam int unsigned SIZE_W  = 7;
  localparam int unsigned SUM_W   = 36;
  localparam int unsigned SQ_IN_W = SUM_W + 8;
  localparam int unsigned NUM_W   = 30;
  localparam int unsigned PROD_W  = 38;

  localparam logic [1:0] STATUS_MERGE    = 2'd0;
  localparam logic [1:0] STATUS_TOO_FEW  = 2'd1;
  localparam logic [1:0] STATUS_TOO_MANY = 2'd2;

  typedef enum logic [16:0] {
    ST_LOAD     = 17'b00000000000000001,
    ST_END      = 17'b00000000000000010,
    ST_PD_RA    = 17'b00000000000000100,
    ST_PD_RB    = 17'b00000000000001000,
    ST_PD_ACC   = 17'b00000000000010000,
    ST_PD_SQ    = 17'b00000000000100000,
    ST_SRCH     = 17'b00000000001000000,
    ST_SRCH_END = 17'b00000000010000000,
    ST_SZ_A     = 17'b00000000100000000,
    ST_SZ_B     = 17'b00000001000000000,
    ST_SZ_C     = 17'b00000010000000000,
    ST_EMIT     = 17'b00000100000000000,
    ST_UP_CHK   = 17'b00001000000000000,
    ST_UP_RB    = 17'b00010000000000000,
    ST_UP_MB    = 17'b00100000000000000,
    ST_UP_DIV   = 17'b01000000000000000,
    ST_FIN      = 17'b10000000000000000
  } alc_state_e;

endpackage

[hw/rtl/alc_isqrt.sv]
// iterative integer square root, two radicand bits per cycle
module alc_isqrt import alc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [SQ_IN_W-1:0]   value_i,
  output logic                 done_o,
  output logic [DIST_W-1:0]    root_o
);

  logic [SQ_IN_W-1:0] rem_q, rem_d;
  logic [SQ_IN_W-1:0] res_q, res_d;
  logic [SQ_IN_W-1:0] bit_q, bit_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [SQ_IN_W:0]   trial;

  always_comb begin
    rem_d  = rem_q;
    res_d  = res_q;
    bit_d  = bit_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {1'b0, res_q} + {1'b0, bit_q};
    if (start_i) begin
      rem_d  = value_i;
      res_d  = '0;
      bit_d  = {2'b01, {(SQ_IN_W-2){1'b0}}};
      busy_d = 1'b1;
    end else if (busy_q) begin
      if ({1'b0, rem_q} >= trial) begin
        rem_d = rem_q - trial[SQ_IN_W-1:0];
        res_d = (res_q >> 1) + bit_q;
      end else begin
        res_d = res_q >> 1;
      end
      bit_d = bit_q >> 2;
      if (bit_q[0]) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    res_q <= res_d;
    bit_q <= bit_d;
  end

  assign done_o = done_q;
  assign root_o = res_q[DIST_W-1:0];

endmodule

[hw/rtl/alc_div.sv]
// restoring divider, one quotient bit per cycle, for the average-link update
module alc_div import alc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [NUM_W-1:0]     num_i,
  input  logic [SIZE_W-1:0]    den_i,
  output logic                 done_o,
  output logic [DIST_W-1:0]    quot_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W);

  logic [NUM_W-1:0]  nq_q, nq_d;
  logic [SIZE_W-1:0] rem_q, rem_d;
  logic [SIZE_W-1:0] den_q, den_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [SIZE_W:0]   shifted;
  logic              qbit;

  always_comb begin
    nq_d    = nq_q;
    rem_d   = rem_q;
    den_d   = den_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    shifted = {rem_q, nq_q[NUM_W-1]};
    qbit    = (shifted >= {1'b0, den_q});
    if (start_i) begin
      nq_d   = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = qbit ? SIZE_W'(shifted - {1'b0, den_q}) : shifted[SIZE_W-1:0];
      nq_d  = {nq_q[NUM_W-2:0], qbit};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(NUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nq_q  <= nq_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = nq_q[DIST_W-1:0];

endmodule

[hw/rtl/average_link_clustering.sv]
// top level of the average-link hierarchical clustering engine
// Coordinates stream in one word per cycle, dims_in_use words per point (sampled at the
// first word of a data set, 0 taken as 1, above 16 taken as 16), up to 64 points; a
// trailing partial point is dropped. The word with tlast closes the set and the input
// stalls until the engine has finished the run. The engine then fills a 128x128 distance
// memory: each pair runs through one shared 16x22 multiplier, one dimension at a time,
// and then through the iterative square root. Each merge scans all pairs of the
// current id space at one memory read per cycle, reads the two cluster sizes, emits a
// merge word, and rebuilds distances to the new cluster with the same multiplier and a
// restoring divider, for every surviving cluster, stepping over each retired id.
// Too many points or fewer than two yields a single status word instead. Result words
// sit in an output register and the engine waits there while the sink back-pressures.
module average_link_clustering import alc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration: points width
  input  logic                cfg_we_i,
  input  logic [DIMS_W-1:0]   cfg_wdata_i,
  // input stream: tdata = coord[15:0]
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [15:0]         s_axis_tdata,
  input  logic                s_axis_tlast,
  // result stream: tdata = cluster_a[6:0], cluster_b[13:7], distance[35:14],
  // merged_size[42:36], zero fill[47:43]
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [47:0]         m_axis_tdata,
  // tuser = status[1:0]
  output logic [1:0]          m_axis_tuser,
  output logic                m_axis_tlast
);

  alc_state_e state_q, state_d;

  // loading counters
  logic [DIMS_W-1:0] dims_q, dims_d;
  logic [DIMS_W-1:0] rdims_q, rdims_d;
  logic [ID_W-1:0]   pc_q, pc_d;
  logic [DIDX_W-1:0] cc_q, cc_d;
  logic              ovf_q, ovf_d;

  // clustering control
  logic [ID_W-1:0]     n_q, n_d;
  logic [ID_W-1:0]     next_q, next_d;
  logic [ID_W-1:0]     act_cnt_q, act_cnt_d;
  logic [ID_SPACE-1:0] active_q, active_d;
  logic [ID_W-1:0]     i_q, i_d, j_q, j_d, m_q, m_d;
  logic [DIDX_W-1:0]   d_q, d_d;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic signed [COORD_W-1:0] pa_q, pa_d;
  logic                found_q, found_d;
  logic [DIST_W-1:0]   best_q, best_d;
  logic [ID_W-1:0]     bi_q, bi_d, bj_q, bj_d;
  logic                pend_q, pend_d;
  logic [ID_W-1:0]     pi_q, pi_d, pj_q, pj_d;
  logic [SIZE_W-1:0]   si_q, si_d, sj_q, sj_d;
  logic [NUM_W-1:0]    acc_q, acc_d;

  // output register
  logic              ov_q, ov_d;
  logic [ID_W-1:0]   oa_q, oa_d, ob_q, ob_d;
  logic [DIST_W-1:0] odist_q, odist_d;
  logic [SIZE_W-1:0] osize_q, osize_d;
  logic [1:0]        ostat_q, ostat_d;
  logic              olast_q, olast_d;

  // memories
  logic signed [COORD_W-1:0] pt_mem [2**PT_AW];
  logic [DIST_W-1:0]         dm_mem [2**DM_AW];
  logic [SIZE_W-1:0]         sz_mem [ID_SPACE];
  logic                      pt_we;
  logic [PT_AW-1:0]          pt_waddr, pt_raddr;
  logic signed [COORD_W-1:0] pt_rdata;
  logic                      dm_we;
  logic [DM_AW-1:0]          dm_waddr, dm_raddr;
  logic [DIST_W-1:0]         dm_wdata, dm_rdata;
  logic                      sz_we;
  logic [ID_W-1:0]           sz_raddr;
  logic [SIZE_W-1:0]         sz_rdata;

  // shared multiplier
  logic [15:0]         mul_a;
  logic [DIST_W-1:0]   mul_b;
  logic [PROD_W-1:0]   prod;

  // iterative units
  logic               sq_start, sq_done;
  logic [SQ_IN_W-1:0] sq_value;
  logic [DIST_W-1:0]  sq_root;
  logic               dv_start, dv_done;
  logic [NUM_W-1:0]   dv_num;
  logic [DIST_W-1:0]  dv_quot;

  // helpers
  logic              in_acc, out_free;
  logic              first_word, wrap_pt;
  logic [DIMS_W-1:0] rd_eff, dims_clamp;
  logic [DIMS_W-1:0] cc_inc;
  logic signed [COORD_W:0] diff;
  logic [COORD_W:0]  diff_mag;
  logic              j_wrap, pair_done;
  logic [SIZE_W-1:0] size_rd;

  function automatic logic [DM_AW-1:0] pair_key(input logic [ID_W-1:0] a,
                                                input logic [ID_W-1:0] b);
    pair_key = (a < b) ? {a, b} : {b, a};
  endfunction

  assign s_axis_tready = (state_q == ST_LOAD);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !ov_q || m_axis_tready;

  assign dims_clamp = (dims_q == '0) ? DIMS_W'(1) :
                      (dims_q > DIMS_W'(MAX_DIMS)) ? DIMS_W'(MAX_DIMS) : dims_q;
  assign first_word = (pc_q == '0) && (cc_q == '0) && !ovf_q;
  assign rd_eff     = first_word ? dims_clamp : rdims_q;
  assign cc_inc     = {1'b0, cc_q} + DIMS_W'(1);
  assign wrap_pt    = (cc_inc >= rd_eff);

  assign diff     = {pa_q[COORD_W-1], pa_q} - {pt_rdata[COORD_W-1], pt_rdata};
  assign diff_mag = diff[COORD_W] ? (COORD_W+1)'(-diff) : diff;

  assign j_wrap    = ({1'b0, j_q} + 8'd1) >= {1'b0, next_q};
  assign pair_done = j_wrap && (({1'b0, i_q} + 8'd2) >= {1'b0, next_q});

  // originals always have size one, merged clusters come from the size memory
  always_comb begin
    size_rd = sz_rdata;
    if (state_q == ST_SZ_B && bi_q < n_q) size_rd = SIZE_W'(1);
    if (state_q == ST_SZ_C && bj_q < n_q) size_rd = SIZE_W'(1);
  end

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_q == ST_PD_ACC) begin
      mul_a = diff_mag[15:0];
      mul_b = {6'b0, diff_mag[15:0]};
    end else if (state_q == ST_UP_RB) begin
      mul_a = {9'b0, si_q};
      mul_b = dm_rdata;
    end else if (state_q == ST_UP_MB) begin
      mul_a = {9'b0, sj_q};
      mul_b = dm_rdata;
    end
  end
  assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

  always_comb begin
    state_d   = state_q;
    dims_d    = dims_q;
    rdims_d   = rdims_q;
    pc_d      = pc_q;
    cc_d      = cc_q;
    ovf_d     = ovf_q;
    n_d       = n_q;
    next_d    = next_q;
    act_cnt_d = act_cnt_q;
    active_d  = active_q;
    i_d       = i_q;
    j_d       = j_q;
    m_d       = m_q;
    d_d       = d_q;
    sum_d     = sum_q;
    pa_d      = pa_q;
    found_d   = found_q;
    best_d    = best_q;
    bi_d      = bi_q;
    bj_d      = bj_q;
    pend_d    = 1'b0;
    pi_d      = pi_q;
    pj_d      = pj_q;
    si_d      = si_q;
    sj_d      = sj_q;
    acc_d     = acc_q;

    ov_d    = ov_q && !m_axis_tready;
    oa_d    = oa_q;
    ob_d    = ob_q;
    odist_d = odist_q;
    osize_d = osize_q;
    ostat_d = ostat_q;
    olast_d = olast_q;

    pt_we    = 1'b0;
    pt_waddr = {pc_q[PIDX_W-1:0], cc_q};
    pt_raddr = {i_q[PIDX_W-1:0], d_q};
    dm_we    = 1'b0;
    dm_waddr = {i_q, j_q};
    dm_wdata = sq_root;
    dm_raddr = {i_q, j_q};
    sz_we    = 1'b0;
    sz_raddr = bi_q;
    sq_start = 1'b0;
    sq_value = {sum_q + prod[SUM_W-1:0], 8'b0};
    dv_start = 1'b0;
    dv_num   = acc_q + prod[NUM_W-1:0];

    if (cfg_we_i) dims_d = cfg_wdata_i;

    // pending pair compare from the previous search read
    if (pend_q && (!found_q || dm_rdata < best_q)) begin
      found_d = 1'b1;
      best_d  = dm_rdata;
      bi_d    = pi_q;
      bj_d    = pj_q;
    end

    unique case (state_q)
      ST_LOAD: begin
        if (in_acc) begin
          if (first_word) rdims_d = dims_clamp;
          pt_we = (pc_q < ID_W'(MAX_POINTS));
          cc_d  = wrap_pt ? '0 : cc_inc[DIDX_W-1:0];
          if (wrap_pt) begin
            if (pc_q < ID_W'(MAX_POINTS)) pc_d = pc_q + 1'b1;
            else                          ovf_d = 1'b1;
          end
          if (s_axis_tlast) state_d = ST_END;
        end
      end
      ST_END: begin
        if (ovf_q || pc_q < ID_W'(2)) begin
          if (out_free) begin
            ov_d    = 1'b1;
            oa_d    = '0;
            ob_d    = '0;
            odist_d = '0;
            osize_d = '0;
            ostat_d = ovf_q ? STATUS_TOO_MANY : STATUS_TOO_FEW;
            olast_d = 1'b1;
            pc_d    = '0;
            cc_d    = '0;
            ovf_d   = 1'b0;
            state_d = ST_LOAD;
          end
        end else begin
          n_d       = pc_q;
          next_d    = pc_q;
          act_cnt_d = pc_q;
          for (int k = 0; k < ID_SPACE; k++) begin
            active_d[k] = (ID_W'(k) < pc_q);
          end
          i_d     = '0;
          j_d     = ID_W'(1);
          d_d     = '0;
          sum_d   = '0;
          pc_d    = '0;
          cc_d    = '0;
          ovf_d   = 1'b0;
          state_d = ST_PD_RA;
        end
      end
      ST_PD_RA: begin
        pt_raddr = {i_q[PIDX_W-1:0], d_q};
        state_d  = ST_PD_RB;
      end
      ST_PD_RB: begin
        pt_raddr = {j_q[PIDX_W-1:0], d_q};
        pa_d     = pt_rdata;
        state_d  = ST_PD_ACC;
      end
      ST_PD_ACC: begin
        sum_d = sum_q + prod[SUM_W-1:0];
        if ({1'b0, d_q} + DIMS_W'(1) == rdims_q) begin
          sq_start = 1'b1;
          state_d  = ST_PD_SQ;
        end else begin
          d_d     = d_q + 1'b1;
          state_d = ST_PD_RA;
        end
      end
      ST_PD_SQ: begin
        if (sq_done) begin
          dm_we    = 1'b1;
          dm_waddr = {i_q, j_q};
          dm_wdata = sq_root;
          d_d      = '0;
          sum_d    = '0;
          if (pair_done) begin
            i_d     = '0;
            j_d     = ID_W'(1);
            found_d = 1'b0;
            state_d = ST_SRCH;
          end else begin
            if (!j_wrap) begin
              j_d = j_q + 1'b1;
            end else begin
              i_d = i_q + 1'b1;
              j_d = i_q + ID_W'(2);
            end
            state_d = ST_PD_RA;
          end
        end
      end
      ST_SRCH: begin
        dm_raddr = {i_q, j_q};
        pend_d   = active_q[i_q] && active_q[j_q];
        pi_d     = i_q;
        pj_d     = j_q;
        if (pair_done) begin
          state_d = ST_SRCH_END;
        end else if (!j_wrap) begin
          j_d = j_q + 1'b1;
        end else begin
          i_d = i_q + 1'b1;
          j_d = i_q + ID_W'(2);
        end
      end
      ST_SRCH_END: begin
        state_d = ST_SZ_A;
      end
      ST_SZ_A: begin
        sz_raddr = bi_q;
        state_d  = ST_SZ_B;
      end
      ST_SZ_B: begin
        sz_raddr = bj_q;
        si_d     = size_rd;
        state_d  = ST_SZ_C;
      end
      ST_SZ_C: begin
        sj_d    = size_rd;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          sz_we   = 1'b1;
          ov_d    = 1'b1;
          oa_d    = bi_q;
          ob_d    = bj_q;
          odist_d = best_q;
          osize_d = si_q + sj_q;
          ostat_d = STATUS_MERGE;
          olast_d = (act_cnt_q == ID_W'(2));
          m_d     = '0;
          state_d = ST_UP_CHK;
        end
      end
      ST_UP_CHK: begin
        dm_raddr = pair_key(bi_q, m_q);
        if (m_q == next_q) begin
          state_d = ST_FIN;
        end else if (active_q[m_q] && m_q != bi_q && m_q != bj_q) begin
          state_d = ST_UP_RB;
        end else begin
          m_d = m_q + 1'b1;
        end
      end
      ST_UP_RB: begin
        dm_raddr = pair_key(bj_q, m_q);
        acc_d    = prod[NUM_W-1:0];
        state_d  = ST_UP_MB;
      end
      ST_UP_MB: begin
        dv_start = 1'b1;
        state_d  = ST_UP_DIV;
      end
      ST_UP_DIV: begin
        if (dv_done) begin
          dm_we    = 1'b1;
          dm_waddr = {m_q, next_q};
          dm_wdata = dv_quot;
          m_d      = m_q + 1'b1;
          state_d  = ST_UP_CHK;
        end
      end
      ST_FIN: begin
        active_d[bi_q]   = 1'b0;
        active_d[bj_q]   = 1'b0;
        active_d[next_q] = 1'b1;
        next_d           = next_q + 1'b1;
        act_cnt_d        = act_cnt_q - 1'b1;
        if (act_cnt_q == ID_W'(2)) begin
          state_d = ST_LOAD;
        end else begin
          i_d     = '0;
          j_d     = ID_W'(1);
          found_d = 1'b0;
          state_d = ST_SRCH;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_LOAD;
      dims_q    <= DIMS_W'(2);
      rdims_q   <= DIMS_W'(2);
      pc_q      <= '0;
      cc_q      <= '0;
      ovf_q     <= 1'b0;
      n_q       <= '0;
      next_q    <= '0;
      act_cnt_q <= '0;
      active_q  <= '0;
      i_q       <= '0;
      j_q       <= '0;
      m_q       <= '0;
      d_q       <= '0;
      found_q   <= 1'b0;
      pend_q    <= 1'b0;
      ov_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      dims_q    <= dims_d;
      rdims_q   <= rdims_d;
      pc_q      <= pc_d;
      cc_q      <= cc_d;
      ovf_q     <= ovf_d;
      n_q       <= n_d;
      next_q    <= next_d;
      act_cnt_q <= act_cnt_d;
      active_q  <= active_d;
      i_q       <= i_d;
      j_q       <= j_d;
      m_q       <= m_d;
      d_q       <= d_d;
      found_q   <= found_d;
      pend_q    <= pend_d;
      ov_q      <= ov_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    sum_q   <= sum_d;
    pa_q    <= pa_d;
    best_q  <= best_d;
    bi_q    <= bi_d;
    bj_q    <= bj_d;
    pi_q    <= pi_d;
    pj_q    <= pj_d;
    si_q    <= si_d;
    sj_q    <= sj_d;
    acc_q   <= acc_d;
    oa_q    <= oa_d;
    ob_q    <= ob_d;
    odist_q <= odist_d;
    osize_q <= osize_d;
    ostat_q <= ostat_d;
    olast_q <= olast_d;
  end

  // point store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (pt_we) pt_mem[pt_waddr] <= $signed(s_axis_tdata);
    pt_rdata <= pt_mem[pt_raddr];
  end

  // distance memory, pair key is lower id then higher id
  always_ff @(posedge clk_i) begin
    if (dm_we) dm_mem[dm_waddr] <= dm_wdata;
    dm_rdata <= dm_mem[dm_raddr];
  end

  // sizes of merged clusters
  always_ff @(posedge clk_i) begin
    if (sz_we) sz_mem[next_q] <= si_q + sj_q;
    sz_rdata <= sz_mem[sz_raddr];
  end

  alc_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .value_i (sq_value),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  alc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dv_start),
    .num_i   (dv_num),
    .den_i   (si_q + sj_q),
    .done_o  (dv_done),
    .quot_o  (dv_quot)
  );

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {5'b0, osize_q, odist_q, ob_q, oa_q};
  assign m_axis_tuser  = ostat_q;
  assign m_axis_tlast  = olast_q;

endmodule
